FILE: src/tesp_pkg.sv
`timescale 1ns / 1ps

package tesp_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_ELECTRODES = 2;
    localparam int DEF_COUNT_BITS = 16;

    // Fixed field widths
    localparam int THRESH_BITS    = 16;
    localparam int SCAN_BITS      = 16;
    localparam int POS_BITS       = 7;
    localparam int DELTA_BITS     = 16;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;

    // Full scale of the slider position
    localparam int FULL_SCALE = 100;

    // Threshold reset value
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(100);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_THRESHOLD_FIRST  = 8'd0,
        REG_THRESHOLD_SECOND = 8'd1
    } tesp_reg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB,
        ST_EVAL,
        ST_DIV_A,
        ST_DIV_B,
        ST_DONE
    } tesp_state_t;

endpackage

FILE: src/two_electrode_slider_position_top.sv
`timescale 1ns / 1ps
// A scan request runs the serial delta subtract, then the touch test; with a touch, two
// serial 7-bit quotients follow, without one the two divisions are skipped. A calibration
// request skips the subtract. A new request is accepted only once the previous result has
// been loaded into the output register, so a stalled result side holds the flow. Reset
// (aresetn low, synchronous): thresholds 100, baselines and deltas zero, scan pointer on the
// first electrode, no result.
module two_electrode_slider_position_top import tesp_pkg::*; #(
    parameter int ELECTRODES = DEF_ELECTRODES,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    // Input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,   // scan_count[15:0], cal_electrode[16], pad
    input  logic                      s_tuser,   // mode
    // Result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata    // position[6:0], touched[7],
                                                 // next_electrode[8], latest_delta[24:9], pad
);

    localparam int PW = $clog2(ELECTRODES);
    localparam int SW = COUNT_BITS + 1;
    localparam int NW = COUNT_BITS + POS_BITS;

    logic [THRESH_BITS-1:0] thr0_reg, thr1_reg;
    logic [COUNT_BITS-1:0]  base_reg  [ELECTRODES];
    logic [COUNT_BITS-1:0]  delta_reg [ELECTRODES];
    logic [PW-1:0]          ptr_reg;
    tesp_state_t            state_reg, state_next;
    logic [COUNT_BITS-1:0]  latest_reg;
    logic [POS_BITS-1:0]    a_reg;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic                   hit_reg;
    logic                   m_valid_reg;
    logic [31:0]            m_data_reg;

    logic                   s_fire, m_fire;
    logic                   sub_start, sub_done;
    logic [COUNT_BITS-1:0]  sub_result;
    logic                   div_start, div_done;
    logic [POS_BITS-1:0]    div_q;
    logic [NW-1:0]          dividend;
    logic [SW-1:0]          delta_sum;
    logic                   hit;
    logic [7:0]             pos_sum;
    logic                   out_load;
    logic [PW-1:0]          cal_idx;

    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_valid_reg && m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign cal_idx   = PW'(s_tdata[16]);

    // Serial delta subtract
    assign sub_start = s_fire && !s_tuser;

    tesp_sub #(.W(COUNT_BITS)) u_sub (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (sub_start),
        .minuend    (s_tdata[COUNT_BITS-1:0]),
        .subtrahend (base_reg[ptr_reg]),
        .done       (sub_done),
        .result     (sub_result)
    );

    // Touch test and shared divider operands
    assign hit = (THRESH_BITS'(delta_reg[0]) > thr0_reg) ||
                 (THRESH_BITS'(delta_reg[1]) > thr1_reg);
    assign delta_sum = {1'b0, delta_reg[0]} + {1'b0, delta_reg[1]};
    assign dividend  = (state_reg == ST_EVAL)
                     ? NW'(delta_reg[0]) * NW'(FULL_SCALE)
                     : NW'(delta_reg[1]) * NW'(FULL_SCALE);

    tesp_div #(.DW(SW), .QW(POS_BITS)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (delta_sum),
        .done     (div_done),
        .quotient (div_q)
    );

    assign pos_sum = 8'(FULL_SCALE) - {1'b0, a_reg} + {1'b0, div_q};

    // Sequencer
    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        out_load   = 1'b0;
        pos_next   = pos_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = s_tuser ? ST_EVAL : ST_SUB;
                end
            end
            ST_SUB: begin
                if (sub_done) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (hit) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_A;
                end else begin
                    pos_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DIV_A: begin
                if (div_done) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_B;
                end
            end
            ST_DIV_B: begin
                if (div_done) begin
                    pos_next   = pos_sum[7:1];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Thresholds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr0_reg <= THRESH_RESET;
            thr1_reg <= THRESH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_THRESHOLD_FIRST) begin
                thr0_reg <= cfg_data;
            end else if (cfg_index == REG_THRESHOLD_SECOND) begin
                thr1_reg <= cfg_data;
            end
        end
    end

    // Baselines, deltas and scan pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ELECTRODES; i++) begin
                base_reg[i]  <= '0;
                delta_reg[i] <= '0;
            end
            ptr_reg <= '0;
        end else begin
            if (s_fire && s_tuser) begin
                base_reg[cal_idx] <= s_tdata[COUNT_BITS-1:0];
            end
            if (state_reg == ST_SUB && sub_done) begin
                delta_reg[ptr_reg] <= sub_result;
                if (ptr_reg == PW'(ELECTRODES - 1)) begin
                    ptr_reg <= '0;
                end else begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end
        end
    end

    // Per-request working registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            latest_reg <= '0;
        end else if (state_reg == ST_SUB && sub_done) begin
            latest_reg <= sub_result;
        end
        if (state_reg == ST_EVAL) begin
            hit_reg <= hit;
        end
        if (state_reg == ST_DIV_A && div_done) begin
            a_reg <= div_q;
        end
        pos_reg <= pos_next;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_fire) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_data_reg <= {7'd0, DELTA_BITS'(latest_reg), ptr_reg[0], hit_reg, pos_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: src/tesp_sub.sv
`timescale 1ns / 1ps

// Bit-serial subtractor, LSB first, result clamped to zero on borrow.
module tesp_sub import tesp_pkg::*; #(
    parameter int W = DEF_COUNT_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] minuend,
    input  logic [W-1:0] subtrahend,
    output logic         done,
    output logic [W-1:0] result
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  d_reg, d_next;
    logic          borrow_reg, borrow_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          diff_bit;

    // One bit of difference and borrow per cycle
    always_comb begin
        a_next      = a_reg;
        b_next      = b_reg;
        d_next      = d_reg;
        borrow_next = borrow_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        diff_bit    = a_reg[0] ^ b_reg[0] ^ borrow_reg;
        if (start) begin
            a_next      = minuend;
            b_next      = subtrahend;
            borrow_next = 1'b0;
            cnt_next    = CW'(W);
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            a_next      = a_reg >> 1;
            b_next      = b_reg >> 1;
            d_next      = {diff_bit, d_reg[W-1:1]};
            borrow_next = (~a_reg[0] & b_reg[0]) |
                          (~(a_reg[0] ^ b_reg[0]) & borrow_reg);
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg      <= a_next;
        b_reg      <= b_next;
        d_reg      <= d_next;
        borrow_reg <= borrow_next;
        cnt_reg    <= cnt_next;
    end

    assign done   = done_reg;
    assign result = borrow_reg ? '0 : d_reg;

endmodule

FILE: src/tesp_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, MSB first.
// The quotient must fit in QW bits (dividend < divisor << QW).
module tesp_div import tesp_pkg::*; #(
    parameter int DW = DEF_COUNT_BITS + 1,
    parameter int QW = POS_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DW+QW-2:0]    dividend,
    input  logic [DW-1:0]       divisor,
    output logic                done,
    output logic [QW-1:0]       quotient
);

    localparam int NW = DW + QW - 1;
    localparam int CW = $clog2(QW + 1);

    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] dsh_reg, dsh_next;
    logic [QW-1:0] q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          fits;

    // Compare against the shifted divisor, subtract when it fits
    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        fits      = rem_reg >= dsh_reg;
        if (start) begin
            rem_next  = dividend;
            dsh_next  = {divisor, {(QW-1){1'b0}}};
            q_next    = '0;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[QW-2:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: tb/two_electrode_slider_position_top_test.sv
`timescale 1ns / 1ps

module two_electrode_slider_position_top_test;
    import tesp_pkg::*;

    // Request kinds carried on s_tuser
    localparam logic MODE_SCAN = 1'b0;
    localparam logic MODE_CAL  = 1'b1;

    // Electrode selects for calibration requests
    localparam logic EL_FIRST  = 1'b0;
    localparam logic EL_SECOND = 1'b1;

    // Register indexes past the end of the map; writes there must be dropped
    localparam logic [CFG_INDEX_BITS-1:0] REG_PAST_END = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_IDX  = '1;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_REPORTS   = 20;

    // One result word, lowest field last
    typedef struct packed {
        logic [6:0]            pad;
        logic [DELTA_BITS-1:0] delta;
        logic                  next_el;
        logic                  touched;
        logic [POS_BITS-1:0]   pos;
    } slider_result_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [23:0]               s_tdata   = '0;
    logic                      s_tuser   = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [31:0]               m_tdata;

    // Shadow state of the slider
    logic [THRESH_BITS-1:0] thr_first  = THRESH_RESET;
    logic [THRESH_BITS-1:0] thr_second = THRESH_RESET;
    logic [SCAN_BITS-1:0]   baseline_mem [2] = '{default: '0};
    logic [DELTA_BITS-1:0]  delta_mem    [2] = '{default: '0};
    logic                   scan_ptr = 1'b0;

    slider_result_t pending_positions[$];
    slider_result_t got_res;
    slider_result_t want_res;

    int          mismatches = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_left = 0;
    int unsigned ready_roll;
    bit          no_idle = 1'b0;

    two_electrode_slider_position_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Position from the two stored deltas, updating the shadow state first
    function automatic slider_result_t predict_position(logic mode, logic [SCAN_BITS-1:0] count,
                                                        logic electrode);
        slider_result_t r;
        int unsigned    d0;
        int unsigned    d1;
        int unsigned    sum;
        int unsigned    a;
        int unsigned    b;
        r = '0;
        if (mode == MODE_CAL) begin
            baseline_mem[electrode] = count;
        end else begin
            // full-width compare, no wrap on large differences
            r.delta = (count > baseline_mem[scan_ptr]) ? count - baseline_mem[scan_ptr] : '0;
            delta_mem[scan_ptr] = r.delta;
            scan_ptr = scan_ptr + 1'b1;
        end
        d0 = delta_mem[0];
        d1 = delta_mem[1];
        r.touched = (d0 > thr_first) || (d1 > thr_second);
        if (r.touched) begin
            sum = d0 + d1;
            a = (d0 * FULL_SCALE) / sum;
            b = (d1 * FULL_SCALE) / sum;
            r.pos = POS_BITS'(((FULL_SCALE - a) + b) / 2);
        end
        r.next_el = scan_ptr;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    // Send one request; valid stays high so back-to-back requests need no re-raise
    task automatic send_request(logic mode, logic [SCAN_BITS-1:0] count, logic electrode);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'b0, electrode, count};
        do @(posedge aclk); while (!s_tready);
        pending_positions.push_back(predict_position(mode, count, electrode));
    endtask

    // Stop sending and wait for every expected result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_positions.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_THRESHOLD_FIRST)
            thr_first = value;
        else if (idx == REG_THRESHOLD_SECOND)
            thr_second = value;
    endtask

    // Block must be idle here
    task automatic load_thresholds(logic [THRESH_BITS-1:0] first, logic [THRESH_BITS-1:0] second,
                                   bit with_stray);
        write_reg(REG_THRESHOLD_FIRST, first);
        if (with_stray) begin
            write_reg(REG_PAST_END, CFG_DATA_BITS'($urandom));
            write_reg(REG_TOP_IDX, CFG_DATA_BITS'($urandom));
        end
        write_reg(REG_THRESHOLD_SECOND, second);
        cfg_valid <= 1'b0;
    endtask

    // Reset thresholds, touch edges and the pointer wrap
    task automatic test_default_thresholds();
        send_request(MODE_SCAN, 16'd0, EL_FIRST);
        send_request(MODE_SCAN, 16'd100, EL_FIRST);   // at threshold, not touched
        send_request(MODE_SCAN, 16'd101, EL_FIRST);   // just over
        send_request(MODE_SCAN, 16'hFFFF, EL_FIRST);
    endtask

    // Baseline capture, count under baseline, wide differences
    task automatic test_calibration();
        send_request(MODE_CAL, 16'hFFFF, EL_FIRST);
        send_request(MODE_CAL, 16'h8000, EL_SECOND);
        send_request(MODE_SCAN, 16'h0000, EL_SECOND); // far below baseline
        send_request(MODE_SCAN, 16'hFFFF, EL_FIRST);
        send_request(MODE_CAL, 16'h0000, EL_SECOND);  // reports stored deltas
        send_request(MODE_SCAN, 16'hFFFF, EL_SECOND); // equal to baseline
        send_request(MODE_SCAN, 16'h1234, EL_FIRST);
        send_request(MODE_CAL, 16'h1234, EL_FIRST);
        send_request(MODE_SCAN, 16'h1234, EL_SECOND);
    endtask

    // Threshold extremes and dropped writes past the register map
    task automatic test_register_writes();
        drain_results();
        load_thresholds(16'd0, 16'd0, 1'b1);
        send_request(MODE_SCAN, 16'd1, EL_FIRST);
        send_request(MODE_SCAN, 16'd0, EL_FIRST);
        drain_results();
        load_thresholds(16'hFFFF, 16'hFFFF, 1'b1);
        send_request(MODE_CAL, 16'd0, EL_FIRST);
        send_request(MODE_CAL, 16'd0, EL_SECOND);
        send_request(MODE_SCAN, 16'hFFFF, EL_FIRST);
        send_request(MODE_SCAN, 16'hFFFF, EL_FIRST);  // never above the top threshold
        drain_results();
        load_thresholds(16'hFFFF, 16'd0, 1'b0);
        send_request(MODE_SCAN, 16'h0001, EL_FIRST);
        send_request(MODE_SCAN, 16'hFFFE, EL_FIRST);
    endtask

    task automatic random_request();
        int unsigned            pick;
        int                     v;
        logic [THRESH_BITS-1:0] thr;
        pick = $urandom_range(0, 19);
        thr  = scan_ptr ? thr_second : thr_first;
        if (pick < 2) begin
            send_request(MODE_CAL, SCAN_BITS'($urandom), 1'($urandom));
        end else if (pick == 2) begin
            send_request(MODE_SCAN, SCAN_BITS'($urandom), 1'($urandom));
        end else if (pick == 3) begin
            send_request(MODE_SCAN, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 1'($urandom));
        end else begin
            // count placed relative to the baseline of the electrode up next
            v = int'(baseline_mem[scan_ptr]);
            case ($urandom_range(0, 3))
                0: v = v - int'($urandom_range(0, 500));
                1: v = v + int'($urandom_range(0, 3000));
                default: v = v + int'(thr) + int'($urandom_range(0, 200)) - 100;
            endcase
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            send_request(MODE_SCAN, SCAN_BITS'(v), 1'($urandom));
        end
    endtask

    // Calibrate both electrodes, then a mostly well-formed scan sequence
    task automatic test_random_phase(logic [THRESH_BITS-1:0] first, logic [THRESH_BITS-1:0] second,
                                     int requests, bit steady, bit hold_midway);
        drain_results();
        load_thresholds(first, second, 1'b0);
        no_idle = steady;
        send_request(MODE_CAL, SCAN_BITS'($urandom_range(0, 20000)), EL_FIRST);
        send_request(MODE_CAL, SCAN_BITS'($urandom_range(0, 20000)), EL_SECOND);
        for (int i = 2; i < requests; i++) begin
            if (hold_midway && i == requests / 2)
                drain_results();
            random_request();
        end
        no_idle = 1'b0;
    endtask

    // Result stall pattern
    always @(posedge aclk) begin
        if (no_idle) begin
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 60) begin
                m_tready <= 1'b1;
            end else begin
                m_tready   <= 1'b0;
                stall_left <= (ready_roll < 92) ? $urandom_range(0, 3) : $urandom_range(20, 60);
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res = slider_result_t'(m_tdata);
            if (pending_positions.size() == 0) begin
                report_mismatch("unexpected result, position", got_res.pos, 0);
            end else begin
                want_res = pending_positions.pop_front();
                if (got_res.pos != want_res.pos)
                    report_mismatch("position", got_res.pos, want_res.pos);
                if (got_res.touched != want_res.touched)
                    report_mismatch("touched", got_res.touched, want_res.touched);
                if (got_res.next_el != want_res.next_el)
                    report_mismatch("next_electrode", got_res.next_el, want_res.next_el);
                if (got_res.delta != want_res.delta)
                    report_mismatch("latest_delta", got_res.delta, want_res.delta);
            end
        end
    end

    // Watchdog on cycles without any accepted request, result or register write
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[two_electrode_slider_position_top] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_thresholds();
        test_calibration();
        test_register_writes();
        test_random_phase(16'd100, 16'd100, 150, 1'b0, 1'b1);
        test_random_phase(16'd0, 16'd0, 120, 1'b1, 1'b0);
        test_random_phase(THRESH_BITS'($urandom_range(0, 3000)),
                          THRESH_BITS'($urandom_range(0, 3000)), 150, 1'b0, 1'b1);
        test_random_phase(16'hFFFF, 16'd0, 100, 1'b0, 1'b0);
        test_random_phase(16'd0, 16'hFFFF, 100, 1'b0, 1'b0);
        test_random_phase(THRESH_BITS'($urandom), THRESH_BITS'($urandom), 100, 1'b0, 1'b0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_positions.size() == 0) begin
            $display("[two_electrode_slider_position_top] OK");
        end else begin
            $display("[two_electrode_slider_position_top] ERROR");
        end
        $finish;
    end

endmodule

FILE: two_electrode_slider_position_top.f
src/tesp_pkg.sv
src/tesp_sub.sv
src/tesp_div.sv
src/two_electrode_slider_position_top.sv
tb/two_electrode_slider_position_top_test.sv
